// File: hdl/i2rd_pkg.sv
// Package for the integer-to-radix-digits block: types, constants and codes.
// Used by every module of the block. No dependencies of its own.
`timescale 1ns / 1ps

package i2rd_pkg;

  // Alphabet limits and the characters that are never digit symbols.
  localparam int MAX_SYMBOLS = 16;
  localparam int SYM_W = 8;
  localparam logic [SYM_W-1:0] SYM_MIN = 8'd32;
  localparam logic [SYM_W-1:0] SYM_MAX = 8'd126;
  localparam logic [SYM_W-1:0] SYM_PLUS = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_MINUS = 8'h2D;

  localparam int COUNT_W = 5;
  localparam int DIGIT_W = 4;
  localparam int VALUE_W = 32;

  // Digit stack: a 32-bit magnitude has at most 32 digits (radix two).
  localparam int DIGIT_DEPTH = 32;
  localparam int SP_W = 6;
  localparam int IDX_W = 5;

  // Divider: eight quotient bits per cycle.
  localparam int DIV_BITS = 8;
  localparam int DIV_CYCLES = VALUE_W / DIV_BITS;
  localparam int STEP_W = 2;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_LOW = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOLS_HIGH = 2'd2;
  localparam logic [COUNT_W-1:0] RST_SYMBOL_COUNT = 5'd10;
  localparam logic [63:0] RST_SYMBOLS_LOW = 64'h3736_3534_3332_3130;
  localparam logic [63:0] RST_SYMBOLS_HIGH = 64'h0000_0000_0000_3938;

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [63:0] high;
    logic [63:0] low;
  } cfg_t;

  // One classified item waiting between front and back.
  typedef struct packed {
    logic neg;
    logic [VALUE_W-1:0] mag;
  } item_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_EMIT
  } back_state_t;

endpackage

// File: hdl/i2rd_front.sv
// Front end: accepts input transactions, checks the alphabet and splits sign and magnitude.
// Depends on i2rd_pkg.
`timescale 1ns / 1ps

module i2rd_front (
  input  logic                      in_push,
  input  logic [31:0]               in_value,
  output logic                      in_full,
  input  i2rd_pkg::cfg_t            cfg,
  input  logic                      q_full,
  output logic                      q_push,
  output i2rd_pkg::item_t           q_item
);

  logic [127:0] alphabet;
  logic [i2rd_pkg::SYM_W-1:0] sym [i2rd_pkg::MAX_SYMBOLS];
  logic alpha_ok;

  assign alphabet = {cfg.high, cfg.low};

  always_comb begin
    for (int i = 0; i < i2rd_pkg::MAX_SYMBOLS; i++) begin
      sym[i] = alphabet[i*i2rd_pkg::SYM_W +: i2rd_pkg::SYM_W];
    end
  end

  // Every symbol in use must be printable, not a sign, and unique.
  always_comb begin
    alpha_ok = (cfg.count >= 5'd2) &&
               (cfg.count <= i2rd_pkg::COUNT_W'(i2rd_pkg::MAX_SYMBOLS));
    for (int i = 0; i < i2rd_pkg::MAX_SYMBOLS; i++) begin
      if (i2rd_pkg::COUNT_W'(i) < cfg.count) begin
        if (sym[i] < i2rd_pkg::SYM_MIN || sym[i] > i2rd_pkg::SYM_MAX ||
            sym[i] == i2rd_pkg::SYM_PLUS || sym[i] == i2rd_pkg::SYM_MINUS) begin
          alpha_ok = 1'b0;
        end
        for (int j = i + 1; j < i2rd_pkg::MAX_SYMBOLS; j++) begin
          if (i2rd_pkg::COUNT_W'(j) < cfg.count && sym[j] == sym[i]) begin
            alpha_ok = 1'b0;
          end
        end
      end
    end
  end

  assign in_full = q_full;
  // Items under an invalid alphabet are accepted and dropped.
  assign q_push = in_push && !q_full && alpha_ok;
  assign q_item.neg = in_value[31];
  assign q_item.mag = in_value[31] ? (~in_value + 32'd1) : in_value;

endmodule

// File: hdl/i2rd_queue.sv
// Two-entry queue of classified items between the front and back ends.
// Depends on i2rd_pkg.
`timescale 1ns / 1ps

module i2rd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  i2rd_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            empty,
  output i2rd_pkg::item_t head
);

  i2rd_pkg::item_t mem_r [2];
  logic wr_ptr_r, wr_ptr_nxt;
  logic rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic do_push, do_pop;

  assign full = (count_r == 2'd2);
  assign empty = (count_r == 2'd0);
  assign head = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: hdl/i2rd_back.sv
// Back end: divides the magnitude by the radix, stacks the digits and emits them.
// Depends on i2rd_pkg.
`timescale 1ns / 1ps

module i2rd_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  i2rd_pkg::cfg_t             cfg,
  input  logic                       q_empty,
  input  i2rd_pkg::item_t            q_head,
  output logic                       q_pop,
  output logic                       out_valid,
  output logic [i2rd_pkg::SYM_W-1:0] out_symbol,
  output logic                       out_is_last,
  input  logic                       out_pop
);

  i2rd_pkg::back_state_t state_r, state_nxt;
  logic [i2rd_pkg::VALUE_W-1:0] div_r, div_nxt;
  logic [i2rd_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [i2rd_pkg::STEP_W-1:0] step_r, step_nxt;
  logic [i2rd_pkg::SP_W-1:0] sp_r, sp_nxt;
  logic sign_r, sign_nxt;
  logic [i2rd_pkg::DIGIT_W-1:0] digits_r [i2rd_pkg::DIGIT_DEPTH];
  logic [i2rd_pkg::VALUE_W-1:0] quo;
  logic [i2rd_pkg::DIGIT_W-1:0] rem_step;
  logic [i2rd_pkg::DIGIT_W-1:0] top_digit;
  logic [i2rd_pkg::IDX_W-1:0] top_idx;
  logic [127:0] alphabet;
  logic digit_push;
  logic out_valid_r, out_valid_nxt;
  logic [i2rd_pkg::SYM_W-1:0] out_symbol_r, out_symbol_nxt;
  logic out_is_last_r, out_is_last_nxt;
  logic slot_free;

  // Eight restoring-division steps; the remainder stays below the radix.
  always_comb begin
    logic [i2rd_pkg::DIGIT_W:0] t;
    logic [i2rd_pkg::DIGIT_W-1:0] r;
    logic [i2rd_pkg::VALUE_W-1:0] d;
    r = rem_r;
    d = div_r;
    for (int k = 0; k < i2rd_pkg::DIV_BITS; k++) begin
      t = {r, d[i2rd_pkg::VALUE_W-1]};
      d = {d[i2rd_pkg::VALUE_W-2:0], 1'b0};
      if (t >= cfg.count) begin
        r = i2rd_pkg::DIGIT_W'(t - cfg.count);
        d[0] = 1'b1;
      end else begin
        r = t[i2rd_pkg::DIGIT_W-1:0];
      end
    end
    quo = d;
    rem_step = r;
  end

  assign alphabet = {cfg.high, cfg.low};
  assign top_idx = i2rd_pkg::IDX_W'(sp_r - 6'd1);
  assign top_digit = digits_r[top_idx];
  assign slot_free = !out_valid_r || out_pop;

  always_comb begin
    state_nxt = state_r;
    div_nxt = div_r;
    rem_nxt = rem_r;
    step_nxt = step_r;
    sp_nxt = sp_r;
    sign_nxt = sign_r;
    q_pop = 1'b0;
    digit_push = 1'b0;
    out_valid_nxt = out_pop ? 1'b0 : out_valid_r;
    out_symbol_nxt = out_symbol_r;
    out_is_last_nxt = out_is_last_r;

    // The sign goes out as soon as the output slot is free.
    if (sign_r && slot_free && state_r != i2rd_pkg::BK_IDLE) begin
      sign_nxt = 1'b0;
      out_valid_nxt = 1'b1;
      out_symbol_nxt = i2rd_pkg::SYM_MINUS;
      out_is_last_nxt = 1'b0;
    end

    unique case (state_r)
      i2rd_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          div_nxt = q_head.mag;
          rem_nxt = '0;
          step_nxt = '0;
          sp_nxt = '0;
          sign_nxt = q_head.neg;
          state_nxt = i2rd_pkg::BK_DIV;
        end
      end
      i2rd_pkg::BK_DIV: begin
        div_nxt = quo;
        rem_nxt = rem_step;
        step_nxt = step_r + 2'd1;
        if (step_r == i2rd_pkg::STEP_W'(i2rd_pkg::DIV_CYCLES - 1)) begin
          digit_push = 1'b1;
          sp_nxt = sp_r + 6'd1;
          rem_nxt = '0;
          if (quo == '0) begin
            state_nxt = i2rd_pkg::BK_EMIT;
          end
        end
      end
      i2rd_pkg::BK_EMIT: begin
        if (!sign_r && slot_free) begin
          out_valid_nxt = 1'b1;
          out_symbol_nxt = alphabet[{top_digit, 3'b000} +: i2rd_pkg::SYM_W];
          out_is_last_nxt = (sp_r == 6'd1);
          sp_nxt = sp_r - 6'd1;
          if (sp_r == 6'd1) begin
            state_nxt = i2rd_pkg::BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = i2rd_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= i2rd_pkg::BK_IDLE;
      sp_r <= '0;
      step_r <= '0;
      sign_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sp_r <= sp_nxt;
      step_r <= step_nxt;
      sign_r <= sign_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_is_last_r <= out_is_last_nxt;
    if (digit_push) begin
      digits_r[sp_r[i2rd_pkg::IDX_W-1:0]] <= rem_step;
    end
  end

  assign out_valid = out_valid_r;
  assign out_symbol = out_symbol_r;
  assign out_is_last = out_is_last_r;

endmodule

// File: hdl/integer_to_radix_digits.sv
// Integer to radix digits, top level: config registers, front end, item queue, back end.
// A '-' for a negative value goes out before its digits. The 8-bit-per-cycle divider
// fills a digit stack that is emptied before the back end takes the next item.
// Reset (synchronous, rst_n low) empties the queue and output and restores alphabet 0..9.
// Depends on i2rd_pkg, i2rd_front, i2rd_queue and i2rd_back.
`timescale 1ns / 1ps

module integer_to_radix_digits (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel: a transaction is taken when in_push is high and in_full is low.
  input  logic        in_push,
  output logic        in_full,
  input  logic [31:0] in_value,
  // Result channel: a transaction completes when out_pop is high and out_empty is low.
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_symbol,
  output logic        out_is_last,
  // Configuration write port.
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  // The alphabet registers. Writes must come only while the block is idle, which the
  // block itself does not enforce; both ends read them directly without any shadow copy.
  i2rd_pkg::cfg_t cfg_r, cfg_nxt;

  logic q_push, q_full, q_pop, q_empty;
  i2rd_pkg::item_t q_item, q_head;
  logic out_valid;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        i2rd_pkg::CFG_SYMBOL_COUNT: cfg_nxt.count = cfg_wdata[i2rd_pkg::COUNT_W-1:0];
        i2rd_pkg::CFG_SYMBOLS_LOW:  cfg_nxt.low = cfg_wdata;
        i2rd_pkg::CFG_SYMBOLS_HIGH: cfg_nxt.high = cfg_wdata;
        default: begin
          // Writes to unused indexes are ignored.
          cfg_nxt = cfg_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.count <= i2rd_pkg::RST_SYMBOL_COUNT;
      cfg_r.low <= i2rd_pkg::RST_SYMBOLS_LOW;
      cfg_r.high <= i2rd_pkg::RST_SYMBOLS_HIGH;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // The front end validates the alphabet and splits the value into sign and
  // magnitude; a transaction under an invalid alphabet is taken and dropped.
  i2rd_front u_front (
    .in_push  (in_push),
    .in_value (in_value),
    .in_full  (in_full),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  // Two classified items can wait here while the back end is busy.
  i2rd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // The back end divides by the radix to fill a digit stack least significant
  // digit first, then drains it most significant first through an output register.
  i2rd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_symbol  (out_symbol),
    .out_is_last (out_is_last),
    .out_pop     (out_pop)
  );

  assign out_empty = !out_valid;

endmodule

// File: hdl/i2rd_checker.sv
// Port-level checker for the integer-to-radix-digits block, bound to the top level.
// Depends on i2rd_pkg and integer_to_radix_digits.
`timescale 1ns / 1ps

module i2rd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_full,
  input logic        out_empty,
  input logic        out_pop,
  input logic [7:0]  out_symbol,
  input logic        out_is_last
);

  // Reset leaves both sides empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (out_empty && !in_full))
    else $error("queues not empty after reset");

  // A sign character is always followed by at least one digit.
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_symbol == i2rd_pkg::SYM_MINUS) |-> !out_is_last)
    else $error("sign character marked as last");

  // A waiting result stays until it is popped.
  a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> !out_empty)
    else $error("result dropped without pop");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> ($stable(out_symbol) && $stable(out_is_last)))
    else $error("result changed while stalled");

endmodule

bind integer_to_radix_digits i2rd_checker u_i2rd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_full     (in_full),
  .out_empty   (out_empty),
  .out_pop     (out_pop),
  .out_symbol  (out_symbol),
  .out_is_last (out_is_last)
);

// File: verif/integer_to_radix_digits_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_to_radix_digits: directed rows, then random phases.
// Depends on i2rd_pkg for constants and register indexes, and on the block's top level.

module integer_to_radix_digits_tb;

  // Index 3 is not a register; writes to it must leave every register unchanged.
  localparam logic [i2rd_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // Clean cycles to wait after the last expected character before touching the
  // registers or ending the run. This covers the longest value (32 binary digits)
  // and an item that has no character to show, for example one that was dropped
  // for a bad alphabet.
  localparam int SETTLE_CYCLES = 200;
  // Cycles with no transaction on any port before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int RANDOM_PHASES = 8;
  localparam int ITEMS_PER_PHASE = 16;

  // One character expected on the result channel.
  typedef struct packed {
    logic [i2rd_pkg::SYM_W-1:0] symbol;
    logic                       is_last;
  } char_t;

  // One row of the directed part: either a register write or a value to convert.
  // When typed is set, text is the exact output string; otherwise the predictor decides.
  typedef struct {
    bit                             is_write;
    logic [i2rd_pkg::CFG_IDX_W-1:0] idx;
    logic [63:0]                    data;
    logic [i2rd_pkg::VALUE_W-1:0]   value;
    bit                             typed;
    string                          text;
  } row_t;

  logic                           clk;
  logic                           rst_n = 1'b0;
  logic                           in_push = 1'b0;
  logic                           in_full;
  logic [i2rd_pkg::VALUE_W-1:0]   in_value = '0;
  logic                           out_empty;
  logic                           out_pop = 1'b0;
  logic [i2rd_pkg::SYM_W-1:0]     out_symbol;
  logic                           out_is_last;
  logic                           cfg_we = 1'b0;
  logic [i2rd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]                    cfg_wdata = '0;

  // Shadow copy of the alphabet registers, updated on every write.
  logic [i2rd_pkg::COUNT_W-1:0] cur_count = i2rd_pkg::RST_SYMBOL_COUNT;
  logic [63:0]                  cur_low = i2rd_pkg::RST_SYMBOLS_LOW;
  logic [63:0]                  cur_high = i2rd_pkg::RST_SYMBOLS_HIGH;

  char_t pending_chars[$];
  row_t  directed_rows[$];
  int    stall_pct = 0;
  int    mismatches = 0;
  int    quiet_cycles = 0;

  integer_to_radix_digits i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_value   (in_value),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_symbol (out_symbol),
    .out_is_last(out_is_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic logic [i2rd_pkg::SYM_W-1:0] sym_of(int idx);
    return (idx < 8) ? cur_low[idx*8 +: 8] : cur_high[(idx-8)*8 +: 8];
  endfunction

  // The alphabet is usable only with 2..16 distinct printable symbols, none of
  // them a sign character. Bytes beyond the count do not matter.
  function automatic bit alphabet_ok();
    if (cur_count < 2 || cur_count > i2rd_pkg::MAX_SYMBOLS) return 1'b0;
    for (int a = 0; a < cur_count; a++) begin
      if (sym_of(a) < i2rd_pkg::SYM_MIN || sym_of(a) > i2rd_pkg::SYM_MAX) return 1'b0;
      if (sym_of(a) == i2rd_pkg::SYM_PLUS || sym_of(a) == i2rd_pkg::SYM_MINUS) return 1'b0;
      for (int b = a + 1; b < cur_count; b++)
        if (sym_of(b) == sym_of(a)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void expect_char(logic [i2rd_pkg::SYM_W-1:0] sym, logic last);
    char_t c;
    c.symbol = sym;
    c.is_last = last;
    pending_chars.push_back(c);
  endfunction

  // Queues the characters that one value turns into under the current alphabet.
  // The magnitude is held at 64 bits, so the most negative value needs no special path.
  function automatic void predict_digits(logic [i2rd_pkg::VALUE_W-1:0] v);
    longint unsigned radix;
    longint unsigned mag;
    longint unsigned place;
    if (!alphabet_ok()) return;
    radix = cur_count;
    if (v[i2rd_pkg::VALUE_W-1]) begin
      mag = 64'h1_0000_0000 - {32'd0, v};
      expect_char(i2rd_pkg::SYM_MINUS, 1'b0);
    end else begin
      mag = {32'd0, v};
    end
    // Weight of the leading digit; zero still yields one digit.
    place = 1;
    while (mag / radix >= place) place *= radix;
    while (place != 0) begin
      expect_char(sym_of(int'(mag / place)), (place / radix) == 0);
      mag %= place;
      place /= radix;
    end
  endfunction

  function automatic void expect_text(string s);
    for (int i = 0; i < s.len(); i++) expect_char(s[i], i == s.len() - 1);
  endfunction

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------

  // Waits until every expected character has come out, then lets the block settle.
  task automatic drain();
    in_push <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers change only while the block is idle, so each write drains first.
  task automatic write_reg(logic [i2rd_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      i2rd_pkg::CFG_SYMBOL_COUNT: cur_count = data[i2rd_pkg::COUNT_W-1:0];
      i2rd_pkg::CFG_SYMBOLS_LOW: cur_low = data;
      i2rd_pkg::CFG_SYMBOLS_HIGH: cur_high = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_alphabet(int n, logic [63:0] lo, logic [63:0] hi);
    write_reg(i2rd_pkg::CFG_SYMBOL_COUNT, 64'(n));
    write_reg(i2rd_pkg::CFG_SYMBOLS_LOW, lo);
    write_reg(i2rd_pkg::CFG_SYMBOLS_HIGH, hi);
  endtask

  // Pushes one value, idling beforehand with the given chance per cycle. The push
  // stays high on return so that back-to-back transactions follow without a gap.
  // Expectations are queued at the edge that accepts the transaction.
  task automatic send_value(logic [i2rd_pkg::VALUE_W-1:0] v, int gap_pct, bit typed,
                            string text);
    while ($urandom_range(99) < gap_pct) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (in_full) @(posedge clk);
    if (typed) expect_text(text);
    else predict_digits(v);
  endtask

  // Picks n distinct usable symbols; the unused bytes get arbitrary values.
  task automatic pick_alphabet(int n, output logic [63:0] lo, output logic [63:0] hi);
    logic [i2rd_pkg::SYM_W-1:0] b [16];
    logic [i2rd_pkg::SYM_W-1:0] c;
    bit clash;
    for (int i = 0; i < 16; i++) b[i] = i2rd_pkg::SYM_W'($urandom_range(255, 0));
    for (int i = 0; i < n; i++) begin
      do begin
        c = i2rd_pkg::SYM_W'($urandom_range(i2rd_pkg::SYM_MAX, i2rd_pkg::SYM_MIN));
        clash = (c == i2rd_pkg::SYM_PLUS) || (c == i2rd_pkg::SYM_MINUS);
        for (int j = 0; j < i; j++) if (b[j] == c) clash = 1'b1;
      end while (clash);
      b[i] = c;
    end
    for (int i = 0; i < 8; i++) begin
      lo[i*8 +: 8] = b[i];
      hi[i*8 +: 8] = b[i+8];
    end
  endtask

  // Values are spread across full-range noise, short numbers, the extremes and
  // numbers right at a power of the radix, where the digit count changes.
  function automatic logic [i2rd_pkg::VALUE_W-1:0] random_value(int radix);
    longint unsigned p;
    int k;
    logic [i2rd_pkg::VALUE_W-1:0] v;
    case ($urandom_range(5, 0))
      0, 1: v = $urandom;
      2: v = $urandom_range(radix * radix, 0);
      3: v = -$urandom_range(radix * radix, 1);
      4: begin
        p = 1;
        k = $urandom_range(31, 0);
        while (k > 0 && p * radix < 64'h8000_0000) begin
          p *= radix;
          k--;
        end
        v = i2rd_pkg::VALUE_W'(p + $urandom_range(2, 0) - 1);
        if ($urandom_range(1, 0)) v = -v;
      end
      default: begin
        case ($urandom_range(3, 0))
          0: v = 32'h8000_0000;
          1: v = 32'h7FFF_FFFF;
          2: v = 32'hFFFF_FFFF;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  function automatic void row_write(logic [i2rd_pkg::CFG_IDX_W-1:0] idx, logic [63:0] data);
    row_t r;
    r.is_write = 1'b1;
    r.idx = idx;
    r.data = data;
    r.value = '0;
    r.typed = 1'b0;
    r.text = "";
    directed_rows.push_back(r);
  endfunction

  function automatic void row_item(logic [i2rd_pkg::VALUE_W-1:0] v, bit typed, string text);
    row_t r;
    r.is_write = 1'b0;
    r.idx = '0;
    r.data = '0;
    r.value = v;
    r.typed = typed;
    r.text = text;
    directed_rows.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver and checking
  // ---------------------------------------------------------------------------

  // The receiver stalls with a chance set per phase.
  always @(posedge clk) begin
    out_pop <= ($urandom_range(99) >= stall_pct);
  end

  // Every character popped off the result channel is compared with the oldest
  // expectation. The same block watches for a hang: a long run of cycles with no
  // transaction on any port ends the test.
  always @(posedge clk) begin : check_results
    char_t want;
    if (rst_n) begin
      if (!out_empty && out_pop) begin
        if (pending_chars.size() == 0) begin
          $error("out_symbol: expected no transaction, got %0h", out_symbol);
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          if (out_symbol !== want.symbol) begin
            $error("out_symbol: expected %0h, got %0h", want.symbol, out_symbol);
            mismatches++;
          end
          if (out_is_last !== want.is_last) begin
            $error("out_is_last: expected %0b, got %0b", want.is_last, out_is_last);
            mismatches++;
          end
        end
      end
      if ((in_push && !in_full) || (!out_empty && out_pop) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  initial begin : stimulus
    logic [63:0] lo;
    logic [63:0] hi;
    logic [i2rd_pkg::SYM_W-1:0] c;
    int n;
    int mode;
    int gap_pct;
    int slot;

    // Directed rows. Out of reset the alphabet is decimal.
    row_item(32'd0, 1'b1, "0");
    row_item(32'h7FFF_FFFF, 1'b1, "2147483647");
    row_item(32'h8000_0000, 1'b1, "-2147483648");
    row_item(32'hFFFF_FFFF, 1'b1, "-1");
    row_item(32'd10, 1'b1, "10");
    // A write to the unused index must not disturb the alphabet.
    row_write(CFG_UNUSED, '1);
    row_item(32'd123, 1'b1, "123");
    // Radix two, the longest outputs.
    row_write(i2rd_pkg::CFG_SYMBOL_COUNT, 64'd2);
    row_item(32'd5, 1'b1, "101");
    row_item(32'h8000_0000, 1'b0, "");
    row_item(32'h7FFF_FFFF, 1'b0, "");
    // Full sixteen-symbol alphabet.
    row_write(i2rd_pkg::CFG_SYMBOL_COUNT, 64'(i2rd_pkg::MAX_SYMBOLS));
    row_write(i2rd_pkg::CFG_SYMBOLS_HIGH, 64'h4645_4443_4241_3938);
    row_item(32'd255, 1'b1, "FF");
    row_item(32'hDEAD_BEEF, 1'b0, "");
    // Bad counts: below two and above sixteen. Nothing comes out.
    row_write(i2rd_pkg::CFG_SYMBOL_COUNT, 64'd0);
    row_item(32'd7, 1'b1, "");
    row_write(i2rd_pkg::CFG_SYMBOL_COUNT, 64'd1);
    row_item(32'd7, 1'b1, "");
    row_write(i2rd_pkg::CFG_SYMBOL_COUNT, 64'd17);
    row_item(32'd7, 1'b1, "");
    row_write(i2rd_pkg::CFG_SYMBOL_COUNT, 64'd31);
    row_item(32'd7, 1'b1, "");
    // Bad symbols with all sixteen in use: a zero byte, above and below the
    // printable range, either sign, and a repeat of symbol 0.
    row_write(i2rd_pkg::CFG_SYMBOL_COUNT, 64'(i2rd_pkg::MAX_SYMBOLS));
    row_write(i2rd_pkg::CFG_SYMBOLS_HIGH, 64'h4645_4443_4241_3900);
    row_item(32'd7, 1'b1, "");
    row_write(i2rd_pkg::CFG_SYMBOLS_HIGH, 64'h7F45_4443_4241_3938);
    row_item(32'd7, 1'b1, "");
    row_write(i2rd_pkg::CFG_SYMBOLS_HIGH, 64'h4645_4443_4241_391F);
    row_item(32'd7, 1'b1, "");
    row_write(i2rd_pkg::CFG_SYMBOLS_HIGH, 64'h4645_4443_4241_2B38);
    row_item(32'd7, 1'b1, "");
    row_write(i2rd_pkg::CFG_SYMBOLS_HIGH, 64'h4645_4443_4241_2D38);
    row_item(32'd7, 1'b1, "");
    row_write(i2rd_pkg::CFG_SYMBOLS_HIGH, 64'h4645_4443_4241_3930);
    row_item(32'd7, 1'b1, "");
    // Space and tilde are the edges of the printable range and are legal.
    row_write(i2rd_pkg::CFG_SYMBOLS_HIGH, 64'h7E20_4443_4241_3938);
    row_item(32'd254, 1'b1, "~ ");
    // Only the bytes in use are checked, so junk beyond the count is fine.
    row_write(i2rd_pkg::CFG_SYMBOL_COUNT, 64'd3);
    row_write(i2rd_pkg::CFG_SYMBOLS_HIGH, '1);
    row_item(32'd5, 1'b1, "12");

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_write) begin
        write_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_value(directed_rows[i].value, 0, directed_rows[i].typed, directed_rows[i].text);
      end
    end

    // Random phases. Each one loads an alphabet and then runs its items under one
    // of four idling modes: none, a slow sender, a slow receiver, or both a little.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      // Halfway through, a burst of broken alphabets, one of each kind of defect.
      // These items are dropped and do not count toward the random total.
      if (p == RANDOM_PHASES / 2) begin
        stall_pct <= 0;
        for (int kind = 0; kind < 6; kind++) begin
          n = $urandom_range(i2rd_pkg::MAX_SYMBOLS, 3);
          pick_alphabet(n, lo, hi);
          slot = $urandom_range(n - 1, 1);
          c = (slot - 1 < 8) ? lo[(slot-1)*8 +: 8] : hi[(slot-9)*8 +: 8];
          case (kind)
            0: n = $urandom_range(1, 0) ? $urandom_range(1, 0) : $urandom_range(31, 17);
            1: c = i2rd_pkg::SYM_W'($urandom_range(i2rd_pkg::SYM_MIN - 1, 0));
            2: c = i2rd_pkg::SYM_W'($urandom_range(255, i2rd_pkg::SYM_MAX + 1));
            3: c = i2rd_pkg::SYM_PLUS;
            4: c = i2rd_pkg::SYM_MINUS;
            default: ;  // c already holds the previous symbol: a repeat
          endcase
          if (kind != 0) begin
            if (slot < 8) lo[slot*8 +: 8] = c;
            else hi[(slot-8)*8 +: 8] = c;
          end
          load_alphabet(n, lo, hi);
          repeat (2) send_value(random_value(10), 0, 1'b0, "");
        end
      end

      case (p)
        0: begin
          n = i2rd_pkg::RST_SYMBOL_COUNT;
          lo = i2rd_pkg::RST_SYMBOLS_LOW;
          hi = i2rd_pkg::RST_SYMBOLS_HIGH;
        end
        1: begin
          n = 2;
          pick_alphabet(n, lo, hi);
        end
        2: begin
          n = i2rd_pkg::MAX_SYMBOLS;
          pick_alphabet(n, lo, hi);
        end
        default: begin
          n = $urandom_range(i2rd_pkg::MAX_SYMBOLS, 2);
          pick_alphabet(n, lo, hi);
        end
      endcase
      load_alphabet(n, lo, hi);

      mode = p % 4;
      gap_pct = (mode == 1) ? 78 : (mode == 3) ? 19 : 0;
      stall_pct <= (mode == 2) ? 78 : (mode == 3) ? 19 : 0;
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        send_value(random_value(n), gap_pct, 1'b0, "");
      end
    end

    drain();
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/i2rd_pkg.sv
hdl/i2rd_front.sv
hdl/i2rd_queue.sv
hdl/i2rd_back.sv
hdl/integer_to_radix_digits.sv
hdl/i2rd_checker.sv
verif/integer_to_radix_digits_tb.sv
